// File: rtl/smt_pkg.sv
package smt_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int OPC_W    = 2;
    localparam int CNT_W    = 7;

    typedef logic [OPC_W-1:0] t_opcode;

    localparam t_opcode OP_INSERT = 2'd0;
    localparam t_opcode OP_REMOVE = 2'd1;
    localparam t_opcode OP_LOOKUP = 2'd2;

endpackage

// File: rtl/smt_ram.sv
module smt_ram #(
    parameter int DEPTH = smt_pkg::CAPACITY,
    parameter int AW    = 6,
    parameter int DW    = smt_pkg::DATA_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sorted_multiset_table.sv
// Ordered table of up to CAPACITY signed 32-bit values, ascending, duplicates kept.
// Each beat in carries an opcode (insert, remove first equal entry, lookup) and a value;
// each produces one beat out with ok, the entry count after the operation and an empty
// flag. Entries live in a single-port-write, single-port-read RAM with a registered read,
// and one comparator walks them one per cycle: an insert walks down from the top entry,
// moving each larger entry up one slot until it finds the place; a remove walks up from
// slot 0 and moves every entry after the match down one slot; a lookup walks up until the
// first match. An insert into a full table or an unused opcode skips the walk and goes
// from idle straight to the done state; every other beat walks the entries in the scan
// state. The done state loads the result into the output register once that is free, and
// returns to idle. o_stall is high while an item is in work. The result sits in an output
// register, so a new beat is taken while the previous result still waits.
module sorted_multiset_table #(
    parameter int CAPACITY = smt_pkg::CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [smt_pkg::OPC_W-1:0]         i_opcode,
    input  logic signed [smt_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_ok,
    output logic [smt_pkg::CNT_W-1:0]         o_entry_count,
    output logic                              o_is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = smt_pkg::DATA_W;
    localparam int OW = smt_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_fill, n_fill;
    logic                    r_pipe, n_pipe;
    logic                    r_out_valid, n_out_valid;
    smt_pkg::t_opcode        r_op, n_op;
    logic signed [DW-1:0]    r_key, n_key;
    logic [CW-1:0]           r_ptr, n_ptr;
    logic [CW-1:0]           r_left, n_left;
    logic [CW-1:0]           r_dpos, n_dpos;
    logic                    r_found, n_found;
    logic                    r_ok, n_ok;
    logic                    r_out_ok, n_out_ok;
    logic [OW-1:0]           r_out_cnt, n_out_cnt;
    logic                    r_out_empty, n_out_empty;

    logic                    w_re, w_we, w_stop;
    logic [AW-1:0]           w_raddr, w_waddr;
    logic [DW-1:0]           w_wdata, w_rdata;
    logic                    w_rd_gt, w_rd_eq;
    logic [CW-1:0]           w_dpos_inc, w_dpos_dec;
    logic [CW+OW-1:0]        w_cnt_ext;

    smt_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // the one shared comparator
    assign w_rd_gt    = $signed(w_rdata) > r_key;
    assign w_rd_eq    = $signed(w_rdata) == r_key;
    assign w_dpos_inc = r_dpos + CNT_ONE;
    assign w_dpos_dec = r_dpos - CNT_ONE;
    assign w_cnt_ext  = {{OW{1'b0}}, r_fill};

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pipe      = r_pipe;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_key       = r_key;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_dpos      = r_dpos;
        n_found     = r_found;
        n_ok        = r_ok;
        n_out_ok    = r_out_ok;
        n_out_cnt   = r_out_cnt;
        n_out_empty = r_out_empty;
        w_re        = 1'b0;
        w_raddr     = r_ptr[AW-1:0];
        w_we        = 1'b0;
        w_waddr     = w_dpos_inc[AW-1:0];
        w_wdata     = r_key;
        w_stop      = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op    = i_opcode;
                    n_key   = i_value;
                    n_pipe  = 1'b0;
                    n_found = 1'b0;
                    n_ok    = 1'b0;
                    n_left  = r_fill;
                    case (i_opcode)
                        smt_pkg::OP_INSERT: begin
                            if (r_fill == CNT_FULL) begin
                                n_state = ST_DONE;
                            end else begin
                                n_ptr   = r_fill - CNT_ONE;
                                n_state = ST_SCAN;
                            end
                        end
                        smt_pkg::OP_REMOVE, smt_pkg::OP_LOOKUP: begin
                            n_ptr   = '0;
                            n_state = ST_SCAN;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end

            ST_SCAN: begin
                // compare side: data read last cycle is at r_dpos
                if (r_pipe) begin
                    case (r_op)
                        smt_pkg::OP_INSERT: begin
                            w_we    = 1'b1;
                            w_waddr = w_dpos_inc[AW-1:0];
                            if (w_rd_gt) begin
                                w_wdata = w_rdata;
                            end else begin
                                w_stop = 1'b1;
                                n_ok   = 1'b1;
                                n_fill = r_fill + CNT_ONE;
                            end
                        end
                        smt_pkg::OP_REMOVE: begin
                            if (r_found) begin
                                w_we    = 1'b1;
                                w_waddr = w_dpos_dec[AW-1:0];
                                w_wdata = w_rdata;
                            end else if (w_rd_eq) begin
                                n_found = 1'b1;
                            end
                        end
                        smt_pkg::OP_LOOKUP: begin
                            if (w_rd_eq) begin
                                w_stop = 1'b1;
                                n_ok   = 1'b1;
                            end
                        end
                        default: w_stop = 1'b1;
                    endcase
                end else if (r_left == '0) begin
                    // walk finished without an early stop
                    w_stop = 1'b1;
                    case (r_op)
                        smt_pkg::OP_INSERT: begin
                            w_we    = 1'b1;
                            w_waddr = '0;
                            w_wdata = r_key;
                            n_ok    = 1'b1;
                            n_fill  = r_fill + CNT_ONE;
                        end
                        smt_pkg::OP_REMOVE: begin
                            n_ok = r_found;
                            if (r_found) begin
                                n_fill = r_fill - CNT_ONE;
                            end
                        end
                        default: n_ok = 1'b0;
                    endcase
                end

                // read side
                if (w_stop) begin
                    n_pipe  = 1'b0;
                    n_state = ST_DONE;
                end else if (r_left != '0) begin
                    w_re   = 1'b1;
                    n_pipe = 1'b1;
                    n_dpos = r_ptr;
                    n_left = r_left - CNT_ONE;
                    n_ptr  = (r_op == smt_pkg::OP_INSERT) ? r_ptr - CNT_ONE : r_ptr + CNT_ONE;
                end else begin
                    n_pipe = 1'b0;
                end
            end

            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_cnt   = w_cnt_ext[OW-1:0];
                    n_out_empty = (r_fill == '0);
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_pipe      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pipe      <= n_pipe;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_ptr       <= n_ptr;
        r_left      <= n_left;
        r_dpos      <= n_dpos;
        r_found     <= n_found;
        r_ok        <= n_ok;
        r_out_ok    <= n_out_ok;
        r_out_cnt   <= n_out_cnt;
        r_out_empty <= n_out_empty;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_entry_count = r_out_cnt;
    assign o_is_empty    = r_out_empty;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |-> !w_we)
        else $error("table write outside a walk");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_FULL)
        else $error("entry count above capacity");

    a_fill_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |=> $stable(r_fill))
        else $error("entry count changed outside a walk");

    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_re && w_we) |-> (w_raddr != w_waddr))
        else $error("read and write hit the same slot");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != ST_IDLE))
        else $error("accepted beat did not start work");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int                RAND_ITEMS = 1550;
    localparam int                DIR_N      = 24;
    localparam int                CYCLE_CAP  = 1_000_000;
    localparam smt_pkg::t_opcode  OP_NONE    = 2'd3;
    localparam logic [31:0]       KEY_MIN    = 32'h8000_0000;
    localparam logic [31:0]       KEY_MAX    = 32'h7fff_ffff;

    typedef struct packed {
        logic                      ok;
        logic [smt_pkg::CNT_W-1:0] count;
        logic                      empty;
    } t_status;

    typedef struct packed {
        smt_pkg::t_opcode op;
        logic [31:0]      key;
        logic             typed;
        t_status          want;
    } t_row;

    typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} t_phase;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    smt_pkg::t_opcode                  i_opcode;
    logic signed [smt_pkg::DATA_W-1:0] i_value;
    logic                              o_valid;
    logic                              i_stall;
    logic                              o_ok;
    logic [smt_pkg::CNT_W-1:0]         o_entry_count;
    logic                              o_is_empty;

    sorted_multiset_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ok          (o_ok),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    // shadow copy of the ordered table
    logic signed [smt_pkg::DATA_W-1:0] shadow_vals [0:smt_pkg::CAPACITY-1];
    int                                shadow_fill;

    t_status awaited_status [$];
    t_row    dir_rows [0:DIR_N-1];

    int n_fail;
    int items_sent;
    int results_checked;
    int full_rejects;
    int empty_hits;
    int hold_left;
    bit hold_done;
    int cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic t_status apply_table_op(input smt_pkg::t_opcode op,
                                               input logic signed [smt_pkg::DATA_W-1:0] key);
        t_status res;
        int      pos;
        res.ok = 1'b0;
        case (op)
            smt_pkg::OP_INSERT: begin
                if (shadow_fill >= smt_pkg::CAPACITY) begin
                    full_rejects++;
                end else begin
                    // entries equal to the key stay in front of it
                    pos = shadow_fill;
                    while (pos > 0 && shadow_vals[pos-1] > key) begin
                        shadow_vals[pos] = shadow_vals[pos-1];
                        pos--;
                    end
                    shadow_vals[pos] = key;
                    shadow_fill++;
                    res.ok = 1'b1;
                end
            end
            smt_pkg::OP_REMOVE: begin
                pos = 0;
                while (pos < shadow_fill && shadow_vals[pos] != key)
                    pos++;
                if (pos < shadow_fill) begin
                    for (int i = pos; i + 1 < shadow_fill; i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_fill--;
                    res.ok = 1'b1;
                    if (shadow_fill == 0)
                        empty_hits++;
                end
            end
            smt_pkg::OP_LOOKUP: begin
                for (int i = 0; i < shadow_fill; i++)
                    if (shadow_vals[i] == key)
                        res.ok = 1'b1;
            end
            default: ;
        endcase
        res.count = shadow_fill[smt_pkg::CNT_W-1:0];
        res.empty = (shadow_fill == 0);
        return res;
    endfunction

    function automatic logic [31:0] pick_key(input bit prefer_stored);
        int r;
        r = $urandom_range(99);
        if (prefer_stored && shadow_fill > 0)
            return shadow_vals[$urandom_range(shadow_fill - 1)];
        if (r < 40)
            return 32'(int'($urandom_range(16)) - 8);
        if (r < 55) begin
            case ($urandom_range(5))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return KEY_MIN + 1;
                3:       return KEY_MAX - 1;
                4:       return 32'hffff_ffff;
                default: return 32'h0;
            endcase
        end
        if (r < 70 && shadow_fill > 0)
            return shadow_vals[$urandom_range(shadow_fill - 1)];
        return $urandom;
    endfunction

    task automatic send_beat(input smt_pkg::t_opcode op, input logic [31:0] key,
                             input logic typed, input t_status want);
        t_status model;
        while (!(items_sent >= 600 && items_sent < 900) && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= key;
        do @(posedge i_clk); while (o_stall);
        model = apply_table_op(op, key);
        awaited_status.push_back(typed ? want : model);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_status.size() != 0);
    endtask

    task automatic random_op(input int p_ins, input int p_rem, input int p_look,
                             input bit rem_stored);
        int               r;
        smt_pkg::t_opcode op;
        r = $urandom_range(99);
        if (r < p_ins)                       op = smt_pkg::OP_INSERT;
        else if (r < p_ins + p_rem)          op = smt_pkg::OP_REMOVE;
        else if (r < p_ins + p_rem + p_look) op = smt_pkg::OP_LOOKUP;
        else                                 op = OP_NONE;
        send_beat(op, pick_key(op == smt_pkg::OP_REMOVE && rem_stored &&
                               $urandom_range(3) != 0),
                  1'b0, '0);
    endtask

    // result side: check every beat and drive stall
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_ok, o_entry_count, o_is_empty};
            if (awaited_status.size() == 0) begin
                $error("result beat with no expectation pending");
                n_fail++;
            end else begin
                want = awaited_status.pop_front();
                if (got.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, got.ok);
                    n_fail++;
                end
                if (got.count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    n_fail++;
                end
                if (got.empty !== want.empty) begin
                    $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
                    n_fail++;
                end
            end
            results_checked++;
        end
        // one long hold-off so the block backs up into its input
        if (!hold_done && results_checked >= 300) begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (results_checked >= 900 && results_checked < 1200) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 16);
        end
    end

    initial begin
        t_phase phase;
        int     extra;
        int     n_mixed;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_opcode        = smt_pkg::OP_INSERT;
        i_value         = '0;
        i_stall         = 1'b0;
        n_fail          = 0;
        items_sent      = 0;
        results_checked = 0;
        full_rejects    = 0;
        empty_hits      = 0;
        hold_left       = 0;
        hold_done       = 1'b0;
        cycles          = 0;
        shadow_fill     = 0;

        dir_rows = '{
            '{smt_pkg::OP_LOOKUP, 32'd0,        1'b1, '{1'b0, 7'd0, 1'b1}},
            '{smt_pkg::OP_REMOVE, 32'd5,        1'b1, '{1'b0, 7'd0, 1'b1}},
            '{OP_NONE,            32'd0,        1'b1, '{1'b0, 7'd0, 1'b1}},
            '{smt_pkg::OP_INSERT, KEY_MIN,      1'b1, '{1'b1, 7'd1, 1'b0}},
            '{smt_pkg::OP_INSERT, KEY_MAX,      1'b1, '{1'b1, 7'd2, 1'b0}},
            '{smt_pkg::OP_LOOKUP, KEY_MIN,      1'b1, '{1'b1, 7'd2, 1'b0}},
            '{smt_pkg::OP_LOOKUP, KEY_MAX,      1'b1, '{1'b1, 7'd2, 1'b0}},
            '{smt_pkg::OP_INSERT, 32'd0,        1'b1, '{1'b1, 7'd3, 1'b0}},
            '{smt_pkg::OP_INSERT, 32'd0,        1'b1, '{1'b1, 7'd4, 1'b0}},
            '{smt_pkg::OP_INSERT, 32'hffffffff, 1'b0, '0},
            '{smt_pkg::OP_LOOKUP, 32'd1,        1'b0, '0},
            '{smt_pkg::OP_REMOVE, 32'd0,        1'b0, '0},
            '{smt_pkg::OP_LOOKUP, 32'd0,        1'b0, '0},
            '{smt_pkg::OP_REMOVE, 32'd0,        1'b0, '0},
            '{smt_pkg::OP_REMOVE, 32'd0,        1'b1, '{1'b0, 7'd3, 1'b0}},
            '{OP_NONE,            32'hffffffff, 1'b1, '{1'b0, 7'd3, 1'b0}},
            '{smt_pkg::OP_REMOVE, KEY_MIN,      1'b0, '0},
            '{smt_pkg::OP_REMOVE, KEY_MAX,      1'b0, '0},
            '{smt_pkg::OP_REMOVE, 32'hffffffff, 1'b1, '{1'b1, 7'd0, 1'b1}},
            '{smt_pkg::OP_INSERT, 32'd7,        1'b0, '0},
            '{smt_pkg::OP_INSERT, 32'd7,        1'b0, '0},
            '{smt_pkg::OP_INSERT, 32'd3,        1'b0, '0},
            '{smt_pkg::OP_REMOVE, 32'd7,        1'b0, '0},
            '{smt_pkg::OP_LOOKUP, 32'd3,        1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++)
            send_beat(dir_rows[k].op, dir_rows[k].key, dir_rows[k].typed, dir_rows[k].want);

        // phases of fill to overflow, mixed traffic and drain to empty
        phase = PH_FILL;
        while (items_sent < DIR_N + RAND_ITEMS) begin
            wait_drained();
            case (phase)
                PH_FILL: begin
                    extra = 0;
                    while (shadow_fill < smt_pkg::CAPACITY || extra < 4) begin
                        if (shadow_fill >= smt_pkg::CAPACITY)
                            extra++;
                        random_op(80, 7, 10, 1'b0);
                    end
                    phase = PH_MIXED;
                end
                PH_DRAIN: begin
                    extra = 0;
                    while (shadow_fill > 0 || extra < 3) begin
                        if (shadow_fill == 0)
                            extra++;
                        random_op(5, 75, 17, 1'b1);
                    end
                    phase = PH_MIXED;
                end
                default: begin
                    n_mixed = 60;
                    repeat (n_mixed)
                        random_op(40, 30, 27, 1'b1);
                    phase = (shadow_fill > smt_pkg::CAPACITY / 2) ? PH_DRAIN : PH_FILL;
                end
            endcase
        end

        wait_drained();
        repeat (smt_pkg::CAPACITY + 8) @(posedge i_clk);

        $display("%0d operations sent, %0d results checked", items_sent, results_checked);
        $display("inserts refused on a full table: %0d, table emptied by remove: %0d times",
                 full_rejects, empty_hits);
        if (n_fail == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/smt_pkg.sv
rtl/smt_ram.sv
rtl/sorted_multiset_table.sv
sim/testbench.sv
